FILE: design/cssc_pkg.sv
// Shared constants, tables and stage types for the CORDIC sine and cosine block.
package cssc_pkg;

  localparam int FRAC_BITS = 16;

  localparam longint unsigned PI_Q61 = 64'h6487ED5110B4611A;
  localparam longint unsigned DEC_SCALE = 64'd1000000000;

  localparam int OUT_W = 19;

  // Angle constants: pi, 2*pi and pi/2, each truncated separately.
  localparam longint unsigned PI_C = PI_Q61 >> (61 - FRAC_BITS);
  localparam longint unsigned TWO_PI_C = PI_Q61 >> (60 - FRAC_BITS);
  localparam longint unsigned HALF_PI_C = PI_Q61 >> (62 - FRAC_BITS);

  // Width of a reduced angle; the residual angle fits a signed word of the same width.
  localparam int ANG_W = $clog2(TWO_PI_C);
  localparam int TH_W = ANG_W;

  // Magnitude width in the modulo chain and the number of compare/subtract cells.
  localparam int RED_W = (ANG_W > 32) ? ANG_W : 32;
  localparam int RED_STAGES = (ANG_W > 32) ? 1 : 33 - ANG_W;

  // CORDIC rotation cells, one per iteration from i = -1 up to FRAC_BITS.
  localparam int ROT_STAGES = FRAC_BITS + 2;
  localparam int SH_W = $clog2(FRAC_BITS + 1);
  localparam int XY_W = FRAC_BITS + 4;

  localparam longint unsigned ATAN_DEC [32] = '{
    64'd1107148718, 64'd785398163, 64'd463647608, 64'd244978663,
    64'd124354996, 64'd62418811, 64'd31239834, 64'd15623730,
    64'd7812340, 64'd3906231, 64'd1953121, 64'd976562,
    64'd488281, 64'd244141, 64'd122070, 64'd61035,
    64'd30517, 64'd15259, 64'd7629, 64'd3815,
    64'd1907, 64'd954, 64'd477, 64'd238,
    64'd119, 64'd60, 64'd30, 64'd15,
    64'd7, 64'd4, 64'd2, 64'd1
  };

  // Converts a value given in units of 1e-9 into fixed point, truncating.
  function automatic longint unsigned dec_to_fixed(input longint unsigned n);
    return (n << FRAC_BITS) / DEC_SCALE;
  endfunction

  localparam longint unsigned SCALE = dec_to_fixed(64'd271572000);
  localparam int SC_W = $clog2(SCALE + 1);
  localparam logic signed [SC_W:0] SCALE_S = (SC_W + 1)'(SCALE);

  localparam int PROD_W = XY_W + SC_W + 1;
  localparam int SHR_W = PROD_W - FRAC_BITS;
  localparam int EXT_W = (SHR_W > OUT_W) ? SHR_W : OUT_W;

  localparam logic [ANG_W-1:0] TWO_PI_A = ANG_W'(TWO_PI_C);
  localparam logic [ANG_W-1:0] PI_A = ANG_W'(PI_C);
  localparam logic [ANG_W-1:0] HALF_PI_A = ANG_W'(HALF_PI_C);

  // Arctangent step of rotation cell n (iteration n-1).
  function automatic logic signed [TH_W-1:0] atan_step(input int n);
    return TH_W'(dec_to_fixed(ATAN_DEC[n]));
  endfunction

  // Subtrahend of modulo cell j: 2*pi shifted so that the chain works from the top down.
  function automatic logic [RED_W-1:0] red_sub(input int j);
    return RED_W'(TWO_PI_C << (RED_STAGES - 1 - j));
  endfunction

  typedef struct packed {
    logic             valid;
    logic             neg;
    logic [RED_W-1:0] mag;
  } red_t;

  typedef struct packed {
    logic                   valid;
    logic                   neg_sin;
    logic                   neg_cos;
    logic signed [XY_W-1:0] x;
    logic signed [XY_W-1:0] y;
    logic signed [TH_W-1:0] th;
  } rot_t;

endpackage

FILE: design/cssc_mod_cell.sv
// One compare-and-subtract cell of the modulo 2*pi reduction chain.
module cssc_mod_cell (
  input  logic                      clk,
  input  logic                      rst,
  input  logic [cssc_pkg::RED_W-1:0] sub,
  input  cssc_pkg::red_t            d,
  output cssc_pkg::red_t            q
);
  import cssc_pkg::*;

  logic [RED_W-1:0] mag_next;

  assign mag_next = (d.mag >= sub) ? d.mag - sub : d.mag;

  always_ff @(posedge clk) begin
    if (rst) begin
      q.valid <= 1'b0;
    end else begin
      q.valid <= d.valid;
    end
    q.neg <= d.neg;
    q.mag <= mag_next;
  end

endmodule

FILE: design/cssc_fold.sv
// Turns the remainder into [0, 2*pi), folds it into [0, pi/2] and seeds the rotation.
module cssc_fold (
  input  logic           clk,
  input  logic           rst,
  input  cssc_pkg::red_t d,
  output cssc_pkg::rot_t q
);
  import cssc_pkg::*;

  logic [ANG_W-1:0] rem;
  logic [ANG_W-1:0] wrap_next;
  logic             wrap_valid;
  logic [ANG_W-1:0] wrap_a;
  logic             half_valid;
  logic             half_neg_sin;
  logic [ANG_W-1:0] half_a;
  logic [ANG_W-1:0] half_next;
  logic [ANG_W-1:0] quad_next;

  assign rem = d.mag[ANG_W-1:0];
  // A truncating remainder of a negative angle wraps back by one turn.
  assign wrap_next = (d.neg && rem != '0) ? TWO_PI_A - rem : rem;
  assign half_next = (wrap_a > PI_A) ? TWO_PI_A - wrap_a : wrap_a;
  assign quad_next = (half_a > HALF_PI_A) ? PI_A - half_a : half_a;

  always_ff @(posedge clk) begin
    if (rst) begin
      wrap_valid <= 1'b0;
      half_valid <= 1'b0;
      q.valid    <= 1'b0;
    end else begin
      wrap_valid <= d.valid;
      half_valid <= wrap_valid;
      q.valid    <= half_valid;
    end
    wrap_a       <= wrap_next;
    half_a       <= half_next;
    half_neg_sin <= (wrap_a > PI_A);
    q.neg_sin    <= half_neg_sin;
    q.neg_cos    <= (half_a > HALF_PI_A);
    q.x          <= XY_W'(longint'(1) << FRAC_BITS);
    q.y          <= '0;
    q.th         <= signed'(quad_next);
  end

endmodule

FILE: design/cssc_rot_cell.sv
// One CORDIC rotation-mode iteration, registered.
module cssc_rot_cell (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             lshift,
  input  logic [cssc_pkg::SH_W-1:0]        shamt,
  input  logic signed [cssc_pkg::TH_W-1:0] step,
  input  cssc_pkg::rot_t                   d,
  output cssc_pkg::rot_t                   q
);
  import cssc_pkg::*;

  logic signed [XY_W-1:0] xv;
  logic signed [XY_W-1:0] yv;
  logic signed [XY_W-1:0] xs;
  logic signed [XY_W-1:0] ys;
  logic signed [XY_W-1:0] x_next;
  logic signed [XY_W-1:0] y_next;
  logic signed [TH_W-1:0] th_next;

  always_comb begin
    xv = d.x;
    yv = d.y;
    xs = lshift ? (xv <<< 1) : (xv >>> shamt);
    ys = lshift ? (yv <<< 1) : (yv >>> shamt);
    // Rotate towards a zero residual angle.
    if (d.th[TH_W-1]) begin
      x_next  = xv + ys;
      y_next  = yv - xs;
      th_next = d.th + step;
    end else begin
      x_next  = xv - ys;
      y_next  = yv + xs;
      th_next = d.th - step;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      q.valid <= 1'b0;
    end else begin
      q.valid <= d.valid;
    end
    q.neg_sin <= d.neg_sin;
    q.neg_cos <= d.neg_cos;
    q.x       <= x_next;
    q.y       <= y_next;
    q.th      <= th_next;
  end

endmodule

FILE: design/cssc_scale.sv
// Gain correction, quadrant signs and output registers.
module cssc_scale (
  input  logic                        clk,
  input  logic                        rst,
  input  cssc_pkg::rot_t              d,
  output logic                        done,
  output logic signed [cssc_pkg::OUT_W-1:0] sine,
  output logic signed [cssc_pkg::OUT_W-1:0] cosine
);
  import cssc_pkg::*;

  logic                     prod_valid;
  logic                     prod_neg_sin;
  logic                     prod_neg_cos;
  logic signed [PROD_W-1:0] prod_x;
  logic signed [PROD_W-1:0] prod_y;
  logic signed [PROD_W-1:0] prod_x_next;
  logic signed [PROD_W-1:0] prod_y_next;
  logic signed [SHR_W-1:0]  shr_x;
  logic signed [SHR_W-1:0]  shr_y;
  logic signed [EXT_W-1:0]  ext_x;
  logic signed [EXT_W-1:0]  ext_y;
  logic signed [EXT_W-1:0]  cos_next;
  logic signed [EXT_W-1:0]  sin_next;

  assign prod_x_next = d.x * SCALE_S;
  assign prod_y_next = d.y * SCALE_S;

  always_comb begin
    shr_x    = prod_x[PROD_W-1:FRAC_BITS];
    shr_y    = prod_y[PROD_W-1:FRAC_BITS];
    ext_x    = EXT_W'(shr_x);
    ext_y    = EXT_W'(shr_y);
    cos_next = prod_neg_cos ? -ext_x : ext_x;
    sin_next = prod_neg_sin ? -ext_y : ext_y;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prod_valid <= 1'b0;
      done       <= 1'b0;
    end else begin
      prod_valid <= d.valid;
      done       <= prod_valid;
    end
    prod_neg_sin <= d.neg_sin;
    prod_neg_cos <= d.neg_cos;
    prod_x       <= prod_x_next;
    prod_y       <= prod_y_next;
    sine         <= sin_next[OUT_W-1:0];
    cosine       <= cos_next[OUT_W-1:0];
  end

endmodule

FILE: design/cordic_sine_cosine_top.sv
// Top level of the pipelined CORDIC sine and cosine block.
// A result appears on sine and cosine, with done high, once its angle has passed the input
// register, the modulo chain, the fold, the rotation chain and the scale registers; the
// rotation chain lengthens and the modulo chain shortens as the fraction width grows.
// Throughput: one angle per cycle; every stage is a register, so busy never rises.
// Reset clears only the valid flags along the pipeline, so no result from before it leaves afterwards.
// The receiver cannot stall: each result is shown for exactly one cycle.
module cordic_sine_cosine_top (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  output logic                              busy,
  input  logic signed [31:0]                angle,
  output logic                              done,
  output logic signed [cssc_pkg::OUT_W-1:0] sine,
  output logic signed [cssc_pkg::OUT_W-1:0] cosine
);
  import cssc_pkg::*;

  // The pipeline never holds an item back, so every start is a transaction.
  assign busy = 1'b0;

  // Input stage: the modulo chain works on the magnitude of the angle and keeps its sign.
  // The negation of the most negative angle still fits, as an unsigned 32-bit value.
  logic [31:0] mag_in;
  red_t        red_q [RED_STAGES+1];
  rot_t        rot_q [ROT_STAGES+1];

  assign mag_in = angle[31] ? (~$unsigned(angle) + 32'd1) : $unsigned(angle);

  always_ff @(posedge clk) begin
    if (rst) begin
      red_q[0].valid <= 1'b0;
    end else begin
      red_q[0].valid <= start && !busy;
    end
    red_q[0].neg <= angle[31];
    red_q[0].mag <= RED_W'(mag_in);
  end

  // Restoring reduction: each cell removes 2*pi times one power of two, from the
  // largest down to 2*pi itself, leaving the magnitude modulo 2*pi.
  for (genvar j = 0; j < RED_STAGES; j++) begin : g_mod
    cssc_mod_cell u_cell (
      .clk (clk),
      .rst (rst),
      .sub (red_sub(j)),
      .d   (red_q[j]),
      .q   (red_q[j+1])
    );
  end

  // Sign correction and the two folds, registered in turn, yield the starting vector.
  cssc_fold u_fold (
    .clk (clk),
    .rst (rst),
    .d   (red_q[RED_STAGES]),
    .q   (rot_q[0])
  );

  // The rotation chain: the first cell doubles (iteration i = -1, atan 2), the
  // following cells shift right by 0, 1, 2 and so on.
  for (genvar n = 0; n < ROT_STAGES; n++) begin : g_rot
    cssc_rot_cell u_cell (
      .clk    (clk),
      .rst    (rst),
      .lshift (n == 0),
      .shamt  ((n == 0) ? SH_W'(0) : SH_W'(n - 1)),
      .step   (atan_step(n)),
      .d      (rot_q[n]),
      .q      (rot_q[n+1])
    );
  end

  // Gain correction multiply into the product registers, then the arithmetic shift,
  // the quadrant signs and the output registers.
  cssc_scale u_scale (
    .clk    (clk),
    .rst    (rst),
    .d      (rot_q[ROT_STAGES]),
    .done   (done),
    .sine   (sine),
    .cosine (cosine)
  );

endmodule

FILE: tb/sv/tb_cordic_sine_cosine_top.sv
// Self-checking testbench for the pipelined CORDIC sine and cosine block.
module tb_cordic_sine_cosine_top;
  timeunit 1ns;
  timeprecision 1ps;

  // Widths come from the design package so that the ports line up with the block.
  localparam int FRAC  = cssc_pkg::FRAC_BITS;
  localparam int OUT_W = cssc_pkg::OUT_W;

  // Latency of the top level from acceptance to done at 16 fraction bits.
  localparam int PIPE_LAT    = 37;
  localparam int CYCLE_LIMIT = 200000;
  localparam int RANDOM_ANGLES = 550;

  // Pi in Q61, shifted down to the working fraction width. Each constant is truncated
  // on its own, so 2*HALF_PI and PI differ by one LSB; the fold tests rely on that.
  localparam longint unsigned PI_Q61 = 64'h6487ED5110B4611A;
  localparam longint PI_FX      = longint'(PI_Q61 >> (61 - FRAC));
  localparam longint TWO_PI_FX  = longint'(PI_Q61 >> (60 - FRAC));
  localparam longint HALF_PI_FX = longint'(PI_Q61 >> (62 - FRAC));

  // Arctangent steps in units of 1e-9 rad, and the gain correction in units of 1e-9.
  localparam longint unsigned NANO = 64'd1000000000;
  localparam longint GAIN_FX = longint'((64'd271572000 << FRAC) / NANO);
  localparam longint unsigned ATAN_NANO [32] = '{
    64'd1107148718, 64'd785398163, 64'd463647608, 64'd244978663,
    64'd124354996, 64'd62418811, 64'd31239834, 64'd15623730,
    64'd7812340, 64'd3906231, 64'd1953121, 64'd976562,
    64'd488281, 64'd244141, 64'd122070, 64'd61035,
    64'd30517, 64'd15259, 64'd7629, 64'd3815,
    64'd1907, 64'd954, 64'd477, 64'd238,
    64'd119, 64'd60, 64'd30, 64'd15,
    64'd7, 64'd4, 64'd2, 64'd1
  };

  // Directed angles. None of the CORDIC outputs can be worked out by hand to the last
  // bit, so every row is checked against the predictor below. The rows cover the
  // extremes of the 32-bit field, a negative truncated remainder that needs 2*pi added
  // back, and each side of the strict fold boundaries at pi/2, pi and 2*pi.
  localparam int N_DIRECTED = 24;
  localparam logic signed [31:0] DIRECTED_ANGLES [N_DIRECTED] = '{
    32'sd0,
    32'sd1,
    -32'sd1,
    32'sh7FFFFFFF,
    32'sh80000000,
    32'(HALF_PI_FX - 1),
    32'(HALF_PI_FX),
    32'(HALF_PI_FX + 1),
    32'(PI_FX - 1),
    32'(PI_FX),
    32'(PI_FX + 1),
    32'(PI_FX + HALF_PI_FX),
    32'(TWO_PI_FX - 1),
    32'(TWO_PI_FX),
    32'(TWO_PI_FX + 1),
    32'(-HALF_PI_FX),
    32'(-PI_FX),
    32'(-PI_FX - 1),
    32'(-TWO_PI_FX),
    32'(-TWO_PI_FX - 1),
    32'(-(TWO_PI_FX + PI_FX)),
    32'(PI_FX * 5),
    32'sh55555555,
    32'shAAAAAAAA
  };

  // One expected result, with the quadrant the fold chose (sine flip, cosine flip).
  typedef struct {
    logic signed [31:0]      angle;
    logic signed [OUT_W-1:0] sine;
    logic signed [OUT_W-1:0] cosine;
    logic [1:0]              quad;
  } sin_cos_t;

  logic                    clk = 1'b0;
  logic                    rst = 1'b1;
  logic                    start = 1'b0;
  logic signed [31:0]      angle = '0;
  logic                    busy;
  logic                    done;
  logic signed [OUT_W-1:0] sine;
  logic signed [OUT_W-1:0] cosine;

  sin_cos_t pending_sin_cos [$];
  sin_cos_t oldest;
  int       err_count = 0;
  int       n_accepted = 0;
  int       n_results = 0;
  int       quad_hits [4] = '{0, 0, 0, 0};
  int       burst_left = 0;
  int       cycle_count = 0;

  cordic_sine_cosine_top u_top (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .busy   (busy),
    .angle  (angle),
    .done   (done),
    .sine   (sine),
    .cosine (cosine)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Predictor. The angle is reduced with a truncating remainder, lifted into [0, 2*pi),
  // folded into [0, pi/2] while noting which outputs change sign, then rotated through
  // FRAC+2 iterations starting with the doubling step at i = -1. x and y are updated
  // from their old values together, and the final products are shifted arithmetically.
  function automatic sin_cos_t cordic_sin_cos(input logic signed [31:0] ang);
    longint   red;
    longint   x;
    longint   y;
    longint   th;
    longint   xs;
    longint   ys;
    longint   stp;
    longint   s;
    longint   c;
    bit       flip_sin;
    bit       flip_cos;
    int       i;
    sin_cos_t r;
    red = longint'(ang);
    red = red % TWO_PI_FX;
    if (red < 0) red += TWO_PI_FX;
    flip_sin = 1'b0;
    flip_cos = 1'b0;
    if (red > PI_FX) begin
      red = TWO_PI_FX - red;
      flip_sin = 1'b1;
    end
    if (red > HALF_PI_FX) begin
      red = PI_FX - red;
      flip_cos = 1'b1;
    end
    x = longint'(1) << FRAC;
    y = 0;
    th = red;
    for (i = -1; i <= FRAC; i++) begin
      if (i < 0) begin
        xs = x * 2;
        ys = y * 2;
      end else begin
        xs = x >>> i;
        ys = y >>> i;
      end
      stp = longint'((ATAN_NANO[i + 1] << FRAC) / NANO);
      if (th < 0) begin
        x += ys;
        y -= xs;
        th += stp;
      end else begin
        x -= ys;
        y += xs;
        th -= stp;
      end
    end
    c = (x * GAIN_FX) >>> FRAC;
    s = (y * GAIN_FX) >>> FRAC;
    if (flip_sin) s = -s;
    if (flip_cos) c = -c;
    r.angle  = ang;
    r.sine   = OUT_W'(s);
    r.cosine = OUT_W'(c);
    r.quad   = {flip_sin, flip_cos};
    return r;
  endfunction

  // Scoreboard. Everything is sampled at the rising edge, before the block's own
  // registers move, so the checks see the same values that the block acted on. A
  // result is checked before the transaction of the same edge is queued; with the
  // pipeline depth the two can never refer to the same angle.
  always @(posedge clk) begin
    if (!rst) begin
      if (done) begin
        n_results++;
        if (pending_sin_cos.size() == 0) begin
          err_count++;
          $display("%0t: result with nothing expected: sine %0d, cosine %0d",
                   $time, sine, cosine);
        end else begin
          oldest = pending_sin_cos.pop_front();
          if (sine !== oldest.sine) begin
            err_count++;
            $display("%0t: sine mismatch, angle %0d: expected %0d, actual %0d",
                     $time, oldest.angle, oldest.sine, sine);
          end
          if (cosine !== oldest.cosine) begin
            err_count++;
            $display("%0t: cosine mismatch, angle %0d: expected %0d, actual %0d",
                     $time, oldest.angle, oldest.cosine, cosine);
          end
        end
      end
      if (start && !busy) begin
        pending_sin_cos.push_back(cordic_sin_cos(angle));
        quad_hits[pending_sin_cos[$].quad]++;
        n_accepted++;
      end
    end
  end

  // Watchdog: stops the run, reporting errors, once CYCLE_LIMIT is passed.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: timed out with %0d results outstanding", $time,
               pending_sin_cos.size());
      $display("tb_cordic_sine_cosine_top: done, errors");
      $finish;
    end
  end

  // Presents one angle and holds it until a transaction takes place. The angle is
  // driven at the edge and busy is sampled at the following edge, which is the edge
  // that accepts it when busy is low.
  task automatic drive_angle(input logic signed [31:0] v);
    start <= 1'b1;
    angle <= v;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  // Sender pacing: bursts of random length separated by random gaps. Some bursts are
  // long so that the pipeline also runs full for stretches. Junk sits on the angle
  // port during a gap, which the block must ignore while start is low.
  task automatic pace_sender();
    int gap;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      gap = $urandom_range(1, 7);
      start <= 1'b0;
      angle <= $urandom;
      repeat (gap) @(posedge clk);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60)
                                               : $urandom_range(0, 6);
    end
  endtask

  // Random angles: a third from the full 32-bit range (every bit takes both values),
  // the rest either a few turns either side of zero or close to a fold boundary after
  // a random number of whole turns.
  function automatic logic signed [31:0] random_angle();
    longint base;
    int     pick;
    pick = $urandom_range(0, 8);
    if (pick < 3) begin
      return $urandom;
    end else if (pick < 6) begin
      return 32'(longint'($urandom_range(0, 6 * TWO_PI_FX)) - 3 * TWO_PI_FX);
    end else begin
      case ($urandom_range(0, 3))
        0: base = 0;
        1: base = HALF_PI_FX;
        2: base = PI_FX;
        default: base = PI_FX + HALF_PI_FX;
      endcase
      base += (longint'($urandom_range(0, 10)) - 5) * TWO_PI_FX;
      return 32'(base + longint'($urandom_range(0, 6)) - 3);
    end
  endfunction

  initial begin
    int k;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Directed part: walk the table of boundary and extreme angles.
    for (k = 0; k < N_DIRECTED; k++) begin
      drive_angle(DIRECTED_ANGLES[k]);
      pace_sender();
    end

    // Random part with bursty pacing.
    for (k = 0; k < RANDOM_ANGLES; k++) begin
      drive_angle(random_angle());
      pace_sender();
    end
    start <= 1'b0;

    // Drain the pipeline, then give it the full latency again to catch stray results.
    while (pending_sin_cos.size() != 0) @(posedge clk);
    repeat (PIPE_LAT + 8) @(posedge clk);

    $display("Angles accepted: %0d (%0d directed), results checked: %0d, mismatches: %0d",
             n_accepted, N_DIRECTED, n_results, err_count);
    $display("Fold outcomes: plain %0d, cosine negated %0d, sine negated %0d, both %0d",
             quad_hits[0], quad_hits[1], quad_hits[2], quad_hits[3]);
    if (err_count == 0) begin
      $display("tb_cordic_sine_cosine_top: done, clean");
    end else begin
      $display("tb_cordic_sine_cosine_top: done, errors");
    end
    $finish;
  end

endmodule
